// File: src/mfs_pkg.sv
// Shared constants, codes and reset values for the multilevel feedback scheduler.
package mfs_pkg;

	localparam int SLOTS_DEFAULT  = 7;
	localparam int LEVELS_DEFAULT = 3;

	localparam logic [6:0]  FULL_QUANTUM_RESET = 7'd94;
	localparam logic [6:0]  BLOCK_LIMIT_RESET  = 7'd99;
	localparam logic [29:0] NS_PER_SEC         = 30'd1000000000;

	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_FULL_QUANTUM = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LIMIT  = 8'd1;

	typedef enum logic {
		OP_CREATE   = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		EV_CREATED    = 2'd0,
		EV_FULL       = 2'd1,
		EV_DISPATCHED = 2'd2,
		EV_EMPTY      = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		OUT_REQUEUED   = 2'd0,
		OUT_BLOCKED    = 2'd1,
		OUT_TERMINATED = 2'd2
	} outcome_t;

endpackage

// File: src/mfs_slot_table.sv
// Process slot table with busy and held flags, owner ids, levels and a free-slot encoder.
module mfs_slot_table
	import mfs_pkg::*;
#(
	parameter int SLOTS  = SLOTS_DEFAULT,
	parameter int LEVELS = LEVELS_DEFAULT,
	localparam int SW = $clog2(SLOTS),
	localparam int LW = $clog2(LEVELS),
	localparam int FW = 1 + SW,
	localparam int UW = 1 + SW + 16 + 3 + SW + LW
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic [FW-1:0] free,
	input  logic [SW-1:0] rd_slot,
	output logic [15:0]   rd_owner,
	output logic [LW-1:0] rd_level,
	input  logic [UW-1:0] upd
);

	typedef struct packed {
		logic          found;
		logic [SW-1:0] slot;
	} free_t;

	typedef struct packed {
		logic          create;
		logic [SW-1:0] create_slot;
		logic [15:0]   owner;
		logic          demote;
		logic          block;
		logic          retire;
		logic [SW-1:0] slot;
		logic [LW-1:0] level;
	} st_upd_t;

	logic [SLOTS-1:0] busy_q;
	logic [SLOTS-1:0] held_q;
	logic [15:0]      owner_q [SLOTS];
	logic [LW-1:0]    level_q [SLOTS];
	free_t            free_w;
	st_upd_t          upd_w;

	assign upd_w    = upd;
	assign free     = free_w;
	assign rd_owner = owner_q[rd_slot];
	assign rd_level = level_q[rd_slot];

	always_comb begin
		free_w.found = 1'b0;
		free_w.slot  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_w.found = 1'b1;
				free_w.slot  = SW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			held_q <= '0;
		end else begin
			if (upd_w.create) begin
				busy_q[upd_w.create_slot] <= 1'b1;
				held_q[upd_w.create_slot] <= 1'b0;
			end
			if (upd_w.block) begin
				held_q[upd_w.slot] <= 1'b1;
			end
			if (upd_w.retire) begin
				busy_q[upd_w.slot] <= 1'b0;
				held_q[upd_w.slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_w.create) begin
			owner_q[upd_w.create_slot] <= upd_w.owner;
			level_q[upd_w.create_slot] <= '0;
		end
		if (upd_w.demote) begin
			level_q[upd_w.slot] <= upd_w.level;
		end
	end

	// A blocked process always keeps its slot.
	a_held_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q & ~busy_q) == '0)
		else $error("held slot is not busy");

	a_create_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		upd_w.create |-> !busy_q[upd_w.create_slot])
		else $error("create into a busy slot");

	a_dispatch_busy_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_w.demote || upd_w.block || upd_w.retire) |-> busy_q[upd_w.slot])
		else $error("dispatch of a free slot");

endmodule

// File: src/mfs_ready_queues.sv
// Circular ready FIFOs of slot numbers, one per level, with the highest-priority pick.
module mfs_ready_queues
	import mfs_pkg::*;
#(
	parameter int SLOTS  = SLOTS_DEFAULT,
	parameter int LEVELS = LEVELS_DEFAULT,
	localparam int SW = $clog2(SLOTS),
	localparam int LW = $clog2(LEVELS),
	localparam int PKW = 1 + LW + SW,
	localparam int QUW = 1 + LW + 1 + LW + SW
) (
	input  logic           clk,
	input  logic           arst_n,
	output logic [PKW-1:0] pick,
	input  logic [QUW-1:0] upd
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = CW + 1;

	typedef struct packed {
		logic          found;
		logic [LW-1:0] level;
		logic [SW-1:0] slot;
	} pick_t;

	typedef struct packed {
		logic          pop;
		logic [LW-1:0] pop_level;
		logic          push;
		logic [LW-1:0] push_level;
		logic [SW-1:0] push_slot;
	} q_upd_t;

	logic [SW-1:0] entries_q [LEVELS][SLOTS];
	logic [SW-1:0] heads_q   [LEVELS];
	logic [CW-1:0] counts_q  [LEVELS];
	logic [SW-1:0] head_n    [LEVELS];
	logic [CW-1:0] count_n   [LEVELS];
	logic          push_wr;
	logic [SW-1:0] push_pos;
	logic [PW-1:0] pos_sum;
	pick_t         pick_w;
	q_upd_t        upd_w;

	assign upd_w = upd;
	assign pick  = pick_w;

	always_comb begin
		pick_w.found = 1'b0;
		pick_w.level = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (counts_q[l] != '0) begin
				pick_w.found = 1'b1;
				pick_w.level = LW'(l);
			end
		end
		pick_w.slot = entries_q[pick_w.level][heads_q[pick_w.level]];
	end

	// The pop is applied first, so a requeue to the same level appends behind it.
	always_comb begin
		push_wr  = 1'b0;
		push_pos = '0;
		pos_sum  = '0;
		for (int l = 0; l < LEVELS; l++) begin
			head_n[l]  = heads_q[l];
			count_n[l] = counts_q[l];
			if (upd_w.pop && upd_w.pop_level == LW'(l)) begin
				head_n[l]  = (heads_q[l] == SW'(SLOTS - 1)) ? '0 : heads_q[l] + 1'b1;
				count_n[l] = counts_q[l] - 1'b1;
			end
			if (upd_w.push && upd_w.push_level == LW'(l) && count_n[l] < CW'(SLOTS)) begin
				pos_sum    = PW'(head_n[l]) + PW'(count_n[l]);
				push_pos   = (pos_sum >= PW'(SLOTS)) ? SW'(pos_sum - PW'(SLOTS)) : SW'(pos_sum);
				push_wr    = 1'b1;
				count_n[l] = count_n[l] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				heads_q[l]  <= '0;
				counts_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				heads_q[l]  <= head_n[l];
				counts_q[l] <= count_n[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_wr) begin
			entries_q[upd_w.push_level][push_pos] <= upd_w.push_slot;
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		upd_w.pop |-> counts_q[upd_w.pop_level] != '0)
		else $error("pop from an empty ready level");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		upd_w.push |-> push_wr)
		else $error("append to a full ready level");

	a_pick_level0_first: assert property (@(posedge clk) disable iff (!arst_n)
		(counts_q[0] != '0) |-> (pick_w.found && pick_w.level == '0))
		else $error("nonempty top level not picked");

endmodule

// File: src/multilevel_feedback_scheduler_top.sv
// Top level of the multilevel feedback scheduler: input register, decision logic, clock, results.
// An accepted word passes the input register and then the result register before its result strobe.
// Throughput: one word per cycle; busy is held low and start is taken in every cycle.
// The slot and level picks are priority encoders over the slot flags and level counts.
// Reset clears the slot flags, queue heads and counts, the clock and the two limits to defaults.
// Results cannot be stalled; configuration writes are always ready.
module multilevel_feedback_scheduler_top
	import mfs_pkg::*;
#(
	parameter int SLOTS  = SLOTS_DEFAULT,
	parameter int LEVELS = LEVELS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   operation,
	input  logic [15:0]            process_id,
	input  logic [6:0]             outcome_roll,
	input  logic [13:0]            run_ns,
	output logic                   done,
	output logic [1:0]             event_res,
	output logic [2:0]             slot,
	output logic [15:0]            owner_id,
	output logic [1:0]             from_level,
	output logic [1:0]             outcome,
	output logic [1:0]             new_level,
	output logic [31:0]            clock_seconds,
	output logic [29:0]            clock_nanoseconds,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [6:0]             cfg_data
);

	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(LEVELS);

	typedef struct packed {
		logic          found;
		logic [SW-1:0] slot;
	} free_t;

	typedef struct packed {
		logic          create;
		logic [SW-1:0] create_slot;
		logic [15:0]   owner;
		logic          demote;
		logic          block;
		logic          retire;
		logic [SW-1:0] slot;
		logic [LW-1:0] level;
	} st_upd_t;

	typedef struct packed {
		logic          found;
		logic [LW-1:0] level;
		logic [SW-1:0] slot;
	} pick_t;

	typedef struct packed {
		logic          pop;
		logic [LW-1:0] pop_level;
		logic          push;
		logic [LW-1:0] push_level;
		logic [SW-1:0] push_slot;
	} q_upd_t;

	logic          valid_s1;
	logic          op_s1;
	logic [15:0]   pid_s1;
	logic [6:0]    roll_s1;
	logic [13:0]   dtime_s1;

	logic [6:0]    full_quantum_q;
	logic [6:0]    block_limit_q;
	logic [31:0]   seconds_q;
	logic [29:0]   nanoseconds_q;

	logic          done_q;
	event_t        event_q;
	logic [SW-1:0] slot_q;
	logic [15:0]   owner_q;
	logic [LW-1:0] from_q;
	outcome_t      outcome_q;
	logic [LW-1:0] new_level_q;

	free_t         free_w;
	pick_t         pick_w;
	st_upd_t       st_upd;
	q_upd_t        q_upd;
	logic [15:0]   rd_owner;
	logic [LW-1:0] rd_level;

	event_t        event_d;
	logic [SW-1:0] slot_d;
	logic [15:0]   owner_d;
	logic [LW-1:0] from_d;
	outcome_t      outcome_d;
	logic [LW-1:0] new_level_d;
	logic          advance;
	logic [LW-1:0] demoted;
	logic [30:0]   ns_sum;
	logic [29:0]   ns_next;
	logic [31:0]   sec_next;

	logic [31:0]   slot_ext;
	logic [31:0]   from_ext;
	logic [31:0]   new_level_ext;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	mfs_slot_table #(
		.SLOTS  (SLOTS),
		.LEVELS (LEVELS)
	) u_slot_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.free     (free_w),
		.rd_slot  (pick_w.slot),
		.rd_owner (rd_owner),
		.rd_level (rd_level),
		.upd      (st_upd)
	);

	mfs_ready_queues #(
		.SLOTS  (SLOTS),
		.LEVELS (LEVELS)
	) u_ready_queues (
		.clk    (clk),
		.arst_n (arst_n),
		.pick   (pick_w),
		.upd    (q_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= operation;
			pid_s1   <= process_id;
			roll_s1  <= outcome_roll;
			dtime_s1 <= run_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_quantum_q <= FULL_QUANTUM_RESET;
			block_limit_q  <= BLOCK_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FULL_QUANTUM: full_quantum_q <= cfg_data;
				CFG_BLOCK_LIMIT:  block_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign demoted = (rd_level == LW'(LEVELS - 1)) ? rd_level : rd_level + 1'b1;
	assign ns_sum  = {1'b0, nanoseconds_q} + 31'(dtime_s1);

	always_comb begin
		if (ns_sum >= 31'(NS_PER_SEC)) begin
			ns_next  = 30'(ns_sum - 31'(NS_PER_SEC));
			sec_next = seconds_q + 32'd1;
		end else begin
			ns_next  = ns_sum[29:0];
			sec_next = seconds_q;
		end
	end

	always_comb begin
		event_d     = EV_EMPTY;
		slot_d      = '0;
		owner_d     = '0;
		from_d      = '0;
		outcome_d   = OUT_REQUEUED;
		new_level_d = '0;
		advance     = 1'b0;
		st_upd      = '0;
		q_upd       = '0;
		if (valid_s1) begin
			if (op_s1 == OP_CREATE) begin
				if (free_w.found) begin
					event_d            = EV_CREATED;
					slot_d             = free_w.slot;
					owner_d            = pid_s1;
					st_upd.create      = 1'b1;
					st_upd.create_slot = free_w.slot;
					st_upd.owner       = pid_s1;
					q_upd.push         = 1'b1;
					q_upd.push_level   = '0;
					q_upd.push_slot    = free_w.slot;
				end else begin
					event_d = EV_FULL;
				end
			end else if (pick_w.found) begin
				event_d         = EV_DISPATCHED;
				slot_d          = pick_w.slot;
				owner_d         = rd_owner;
				from_d          = pick_w.level;
				advance         = 1'b1;
				q_upd.pop       = 1'b1;
				q_upd.pop_level = pick_w.level;
				st_upd.slot     = pick_w.slot;
				new_level_d     = rd_level;
				if (roll_s1 < full_quantum_q) begin
					outcome_d        = OUT_REQUEUED;
					new_level_d      = demoted;
					st_upd.demote    = 1'b1;
					st_upd.level     = demoted;
					q_upd.push       = 1'b1;
					q_upd.push_level = demoted;
					q_upd.push_slot  = pick_w.slot;
				end else if (roll_s1 < block_limit_q) begin
					outcome_d    = OUT_BLOCKED;
					st_upd.block = 1'b1;
				end else begin
					outcome_d     = OUT_TERMINATED;
					st_upd.retire = 1'b1;
				end
			end else begin
				event_d = EV_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			seconds_q     <= '0;
			nanoseconds_q <= '0;
		end else begin
			done_q <= valid_s1;
			if (advance) begin
				seconds_q     <= sec_next;
				nanoseconds_q <= ns_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			event_q     <= event_d;
			slot_q      <= slot_d;
			owner_q     <= owner_d;
			from_q      <= from_d;
			outcome_q   <= outcome_d;
			new_level_q <= new_level_d;
		end
	end

	assign slot_ext      = 32'(slot_q);
	assign from_ext      = 32'(from_q);
	assign new_level_ext = 32'(new_level_q);

	assign done              = done_q;
	assign event_res         = event_q;
	assign slot              = slot_ext[2:0];
	assign owner_id          = owner_q;
	assign from_level        = from_ext[1:0];
	assign outcome           = outcome_q;
	assign new_level         = new_level_ext[1:0];
	assign clock_seconds     = seconds_q;
	assign clock_nanoseconds = nanoseconds_q;

	a_result_two_later: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing for an accepted word");

	a_ns_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		clock_nanoseconds < NS_PER_SEC)
		else $error("nanoseconds out of range");

	a_clock_moves_on_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(clock_nanoseconds) |-> (done && event_res == EV_DISPATCHED))
		else $error("clock advanced without a dispatch");

	a_seconds_step_one: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(clock_seconds) |-> (clock_seconds == $past(clock_seconds) + 32'd1))
		else $error("seconds advanced by more than one");

endmodule
